// ===== sv/mft_pkg.sv =====
`timescale 1ns / 1ps
// mft_pkg: shared types and codes for the sorted multiset take block.
// No dependencies.
package mft_pkg;

  localparam int TDATA_IN_W  = 40;
  localparam int TDATA_OUT_W = 40;
  localparam int OPER_W      = 32;
  localparam int STAT_W      = 2;

  localparam logic FN_INSERT = 1'b0;
  localparam logic FN_TAKE   = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_NONE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic ins;
    logic take;
  } mft_cmd_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_BUSY = 2'b10
  } mft_state_t;

endpackage

// ===== sv/mft_cell.sv =====
`timescale 1ns / 1ps
// mft_cell: one cell of the sorted chain; holds one value, compares it with
// the broadcast operand and shifts to or from its neighbors. Uses mft_pkg.
module mft_cell import mft_pkg::*; #(
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  mft_cmd_t              cmd,
  input  logic                  occ,
  input  logic [VALUE_BITS-1:0] op_value,
  input  logic                  left_le,
  input  logic [VALUE_BITS-1:0] left_value,
  input  logic                  right_le,
  input  logic [VALUE_BITS-1:0] right_value,
  output logic                  le,
  output logic                  hit,
  output logic [VALUE_BITS-1:0] value
);

  logic [VALUE_BITS-1:0] val_r;
  logic [VALUE_BITS-1:0] val_nxt;

  assign le    = occ && (val_r <= op_value);
  assign hit   = le && !right_le;
  assign value = val_r;

  always_comb begin
    val_nxt = val_r;
    if (cmd.ins && !le) begin
      val_nxt = left_le ? op_value : left_value;
    end else if (cmd.take && !right_le) begin
      val_nxt = right_value;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

// ===== sv/mft_or_tree.sv =====
`timescale 1ns / 1ps
// mft_or_tree: registered binary OR tree that gathers the one selected cell
// value to a single root word. No package dependencies.
module mft_or_tree #(
  parameter int LEAVES = 1024,
  parameter int W      = 32
) (
  input  logic         clk,
  input  logic [W-1:0] leaf_in [LEAVES],
  output logic [W-1:0] root
);

  localparam int LG = $clog2(LEAVES);
  localparam int NP = 1 << LG;

  logic [W-1:0] tree_r [1:2*NP-1];

  always_ff @(posedge clk) begin
    for (int k = 1; k < NP; k++) begin
      tree_r[k] <= tree_r[2*k] | tree_r[2*k+1];
    end
    for (int i = 0; i < NP; i++) begin
      if (i < LEAVES) begin
        tree_r[NP+i] <= leaf_in[i];
      end else begin
        tree_r[NP+i] <= '0;
      end
    end
  end

  assign root = tree_r[1];

endmodule

// ===== sv/multiset_floor_take.sv =====
`timescale 1ns / 1ps
// multiset_floor_take: sorted multiset chain with insert and floor-take.
// Depends on mft_pkg, mft_cell, mft_or_tree.
//
//   channel | dir | word contents (low bit first)
//   in_     | in  | func[0], operand_value[32:1], zero pad
//   out_    | out | status[1:0], taken_value[33:2], zero pad
//
// Insert: the result is registered as the word is accepted; all cells compare and shift.
// Take: the result waits on the registered OR tree that
// collects the removed value from its cell.
// One item in flight; a new word is taken once the result slot is free.
// rst_n clears count and control; cell contents need no reset.
module multiset_floor_take import mft_pkg::*; #(
  parameter int CAPACITY   = 1024,
  parameter int VALUE_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [TDATA_IN_W-1:0]  in_tdata,   // func, operand_value
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [TDATA_OUT_W-1:0] out_tdata   // status, taken_value
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int LG    = $clog2(CAPACITY);
  localparam int LAT_W = $clog2(LG + 2);

  mft_state_t              state_r, state_nxt;
  logic [CNT_W-1:0]        count_r;
  logic [LAT_W-1:0]        lat_r;
  logic                    found_r;
  logic                    out_valid_r;
  logic [TDATA_OUT_W-1:0]  out_data_r;

  logic                    in_fire, out_fire;
  logic                    func;
  logic [VALUE_BITS-1:0]   op_value;
  logic                    full, found;
  mft_cmd_t                cmd;
  logic [VALUE_BITS-1:0]   root;

  logic                    le    [CAPACITY+1];
  logic                    hit   [CAPACITY];
  logic [VALUE_BITS-1:0]   value [CAPACITY+1];
  logic [VALUE_BITS-1:0]   leaf  [CAPACITY];

  assign in_tready  = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign in_fire    = in_tvalid && in_tready;
  assign out_fire   = out_valid_r && out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign func     = in_tdata[0];
  assign op_value = VALUE_BITS'(in_tdata[OPER_W:1]);
  assign full     = (count_r == CNT_W'(CAPACITY));
  assign found    = le[0];
  assign cmd.ins  = in_fire && (func == FN_INSERT) && !full;
  assign cmd.take = in_fire && (func == FN_TAKE) && found;

  assign le[CAPACITY]    = 1'b0;
  assign value[CAPACITY] = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                  occ;
    logic                  lft_le;
    logic [VALUE_BITS-1:0] lft_val;

    assign occ = (CNT_W'(i) < count_r);
    if (i == 0) begin : g_first
      assign lft_le  = 1'b1;
      assign lft_val = '0;
    end else begin : g_rest
      assign lft_le  = le[i-1];
      assign lft_val = value[i-1];
    end

    mft_cell #(.VALUE_BITS(VALUE_BITS)) u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .occ         (occ),
      .op_value    (op_value),
      .left_le     (lft_le),
      .left_value  (lft_val),
      .right_le    (le[i+1]),
      .right_value (value[i+1]),
      .le          (le[i]),
      .hit         (hit[i]),
      .value       (value[i])
    );

    assign leaf[i] = hit[i] ? value[i] : '0;
  end

  mft_or_tree #(.LEAVES(CAPACITY), .W(VALUE_BITS)) u_tree (
    .clk     (clk),
    .leaf_in (leaf),
    .root    (root)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire && (func == FN_TAKE)) begin
          state_nxt = S_BUSY;
        end
      end
      S_BUSY: begin
        if (lat_r == '0) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      lat_r       <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.ins) begin
        count_r <= count_r + 1'b1;
      end else if (cmd.take) begin
        count_r <= count_r - 1'b1;
      end
      if (out_fire) begin
        out_valid_r <= 1'b0;
      end
      if (in_fire) begin
        lat_r   <= LAT_W'(LG);
        found_r <= found;
        if (func == FN_INSERT) begin
          out_valid_r <= 1'b1;
        end
      end else if (state_r == S_BUSY) begin
        if (lat_r == '0) begin
          out_valid_r <= 1'b1;
        end else begin
          lat_r <= lat_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && (func == FN_INSERT)) begin
      out_data_r <= TDATA_OUT_W'({OPER_W'(0), (full ? ST_FULL : ST_OK)});
    end else if ((state_r == S_BUSY) && (lat_r == '0)) begin
      out_data_r <= TDATA_OUT_W'({OPER_W'(root), (found_r ? ST_OK : ST_NONE)});
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("stored count above capacity");

  a_count_moves_on_word: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(count_r) |-> $past(in_fire))
    else $error("stored count changed without an accepted word");

  a_none_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && (out_data_r[STAT_W-1:0] != ST_OK)) |->
      (out_data_r[STAT_W+OPER_W-1:STAT_W] == '0))
    else $error("failed operation returned a nonzero value");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BUSY) |-> !in_fire)
    else $error("word accepted while a take is in flight");
`endif

endmodule

// ===== tb/sv/multiset_floor_take_tb.sv =====
`timescale 1ns / 1ps
// multiset_floor_take_tb: self-checking bench for the sorted multiset take block.
// Depends on mft_pkg and multiset_floor_take; a sorted queue predicts every result.
module multiset_floor_take_tb import mft_pkg::*;;

  localparam int CAPACITY      = 1024;
  localparam int VALUE_BITS    = 32;
  localparam int SETTLE_CYCLES = 24;
  localparam int RX_HOLD       = 300;
  localparam int STALL_LIMIT   = 4000;

  class floor_take_board;
    logic [OPER_W-1:0] held[$];
    logic [STAT_W-1:0] want_status[$];
    logic [OPER_W-1:0] want_value[$];
    int words, stored, refused, found, missed, checked, mismatches;

    function void queue_result(logic [STAT_W-1:0] st, logic [OPER_W-1:0] val);
      want_status.insert(want_status.size(), st);
      want_value.insert(want_value.size(), val);
    endfunction

    function void note_word(logic fn, logic [OPER_W-1:0] operand);
      int pos;
      logic [OPER_W-1:0] got;
      words++;
      pos = held.size();
      if (fn == FN_INSERT) begin
        if (held.size() >= CAPACITY) begin
          refused++;
          queue_result(ST_FULL, '0);
        end else begin
          while (pos > 0 && held[pos-1] > operand) pos--;
          held.insert(pos, operand);
          stored++;
          queue_result(ST_OK, '0);
        end
      end else begin
        while (pos > 0 && held[pos-1] > operand) pos--;
        if (pos == 0) begin
          missed++;
          queue_result(ST_NONE, '0);
        end else begin
          got = held[pos-1];
          held.delete(pos-1);
          found++;
          queue_result(ST_OK, got);
        end
      end
    endfunction

    function void check_word(logic [STAT_W-1:0] st, logic [OPER_W-1:0] val);
      logic [STAT_W-1:0] ws;
      logic [OPER_W-1:0] wv;
      checked++;
      if (want_status.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: status %0d value %h", st, val);
        return;
      end
      ws = want_status.pop_front();
      wv = want_value.pop_front();
      if (st !== ws || val !== wv) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch on word %0d: want status %0d value %h, got status %0d value %h",
                   checked, ws, wv, st, val);
      end
    endfunction

    function int pending();
      return want_status.size();
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [TDATA_IN_W-1:0]  in_tdata;   // func, operand_value
  logic                   out_tvalid;
  logic                   out_tready;
  logic [TDATA_OUT_W-1:0] out_tdata;  // status, taken_value

  floor_take_board board;
  int tx_idle_pct;
  int rx_idle_pct;
  bit rx_hold_req;
  int rx_hold_left;
  int quiet_cycles;

  multiset_floor_take #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // check results before noting new words
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready)
        board.check_word(out_tdata[STAT_W-1:0], out_tdata[STAT_W+OPER_W-1:STAT_W]);
      if (in_tvalid && in_tready)
        board.note_word(in_tdata[0], in_tdata[OPER_W:1]);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d quiet cycles", quiet_cycles);
      $display("status: fail");
      $finish;
    end else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    out_tready = 1'b0;
    rx_hold_left = 0;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        rx_hold_left = RX_HOLD;
        rx_hold_req = 1'b0;
      end
      if (rx_hold_left > 0) begin
        out_tready <= 1'b0;
        rx_hold_left--;
      end else
        out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  function automatic logic [OPER_W-1:0] pick_operand();
    case ($urandom_range(4))
      0: return $urandom_range(31);
      1: return $urandom_range(4095);
      2: begin
        case ($urandom_range(3))
          0: return '0;
          1: return 32'd1;
          2: return 32'hFFFF_FFFE;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_word(input logic fn, input logic [OPER_W-1:0] operand);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(TDATA_IN_W-OPER_W-1){1'b0}}, operand, fn};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic run_mixed(input int count, input int insert_pct);
    repeat (count)
      send_word(($urandom_range(99) < insert_pct) ? FN_INSERT : FN_TAKE, pick_operand());
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    board = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    rx_hold_req = 1'b0;
    quiet_cycles = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty store, extremes, duplicates, floor search
    send_word(FN_TAKE, 32'h0000_0000);
    send_word(FN_TAKE, 32'hFFFF_FFFF);
    send_word(FN_INSERT, 32'h0000_0000);
    send_word(FN_INSERT, 32'hFFFF_FFFF);
    send_word(FN_INSERT, 32'd100);
    send_word(FN_INSERT, 32'd100);
    send_word(FN_INSERT, 32'd50);
    send_word(FN_TAKE, 32'd99);
    send_word(FN_TAKE, 32'd100);
    send_word(FN_TAKE, 32'd100);
    send_word(FN_TAKE, 32'd100);
    send_word(FN_TAKE, 32'd0);
    send_word(FN_TAKE, 32'hFFFF_FFFE);
    send_word(FN_TAKE, 32'hFFFF_FFFF);
    send_word(FN_INSERT, 32'd7);
    send_word(FN_INSERT, 32'hAAAA_AAAA);
    send_word(FN_INSERT, 32'h5555_5555);
    send_word(FN_TAKE, 32'h8000_0000);
    send_word(FN_TAKE, 32'hFFFF_FFFF);
    send_word(FN_TAKE, 32'hFFFF_FFFF);
    send_word(FN_TAKE, 32'hFFFF_FFFF);
    wait_drained();

    tx_idle_pct = 36;
    rx_idle_pct = 70;
    run_mixed(350, 55);

    // hold the receiver while words keep coming, then pause until drained
    rx_hold_req = 1'b1;
    run_mixed(15, 50);
    wait_drained();

    // grow the store with mostly inserts
    tx_idle_pct = 70;
    rx_idle_pct = 36;
    run_mixed(250, 75);
    wait_drained();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_mixed(300, 35);
    wait_drained();

    $display("covered %0d words: %0d inserts stored, %0d refused as full,",
             board.words, board.stored, board.refused);
    $display("%0d takes found, %0d empty; checked %0d results, %0d mismatches, %0d left",
             board.found, board.missed, board.checked, board.mismatches, board.held.size());
    if (board.mismatches == 0 && board.pending() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
